// ===== hw/rtl/last_note_priority_voice_defines.svh =====
// Assertion macros for the last-note-priority voice block
`ifndef LAST_NOTE_PRIORITY_VOICE_DEFINES_SVH
`define LAST_NOTE_PRIORITY_VOICE_DEFINES_SVH

`ifndef SYNTHESIS
`define LNPV_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LNPV_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LNPV_ASSERT(name, prop, msg)
`define LNPV_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/lnpv_pkg.sv =====
// Shared types and constants for the last-note-priority voice block
`default_nettype none

package lnpv_pkg;

    localparam int NOTE_W          = 7;
    localparam int VEL_W           = 7;
    localparam int IN_DATA_W       = 16;
    localparam int OUT_DATA_W      = 16;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int STACK_DEPTH_DEF = 8;

    localparam logic [NOTE_W-1:0] LOWEST_RST  = 7'd0;
    localparam logic [NOTE_W-1:0] HIGHEST_RST = 7'd127;

    // register index, taken from paddr[2]
    localparam logic REG_LOWEST  = 1'b0;
    localparam logic REG_HIGHEST = 1'b1;

    localparam logic FUNC_NOTE_ON  = 1'b0;
    localparam logic FUNC_NOTE_OFF = 1'b1;

    typedef struct packed {
        logic              load_scan;
        logic              shift_scan;
        logic              push;
        logic              remove;
        logic [NOTE_W-1:0] note;
    } stack_cmd_t;

    typedef struct packed {
        logic [NOTE_W-1:0] top_note;
        logic              top_held;
        logic              second_held;
        logic [NOTE_W-1:0] scan_note;
        logic              scan_held;
    } stack_stat_t;

    typedef struct packed {
        logic eq;
        logic le;
    } cmp_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lnpv_cmp.sv =====
// Shared note comparator: equality and less-or-equal
`default_nettype none

module lnpv_cmp (
    input  wire logic [lnpv_pkg::NOTE_W-1:0] a,
    input  wire logic [lnpv_pkg::NOTE_W-1:0] b,
    output lnpv_pkg::cmp_res_t               res
);

    always_comb
    begin
        res.eq = (a == b);
        res.le = (a <= b);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lnpv_stack.sv =====
// Held-note stack with push, compacting remove and a scan line for the search walk
`default_nettype none

module lnpv_stack #(
    parameter int DEPTH = lnpv_pkg::STACK_DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lnpv_pkg::stack_cmd_t cmd,
    input  wire logic [IDX_W-1:0]     rm_idx,
    output lnpv_pkg::stack_stat_t     stat
);

    logic [lnpv_pkg::NOTE_W-1:0] notes_reg [DEPTH];
    logic [lnpv_pkg::NOTE_W-1:0] notes_next [DEPTH];
    logic                        held_reg [DEPTH];
    logic                        held_next [DEPTH];
    logic [lnpv_pkg::NOTE_W-1:0] scan_note_reg [DEPTH];
    logic [lnpv_pkg::NOTE_W-1:0] scan_note_next [DEPTH];
    logic                        scan_held_reg [DEPTH];
    logic                        scan_held_next [DEPTH];

    always_comb
    begin
        notes_next = notes_reg;
        held_next  = held_reg;
        if (cmd.push)
        begin
            if (!held_reg[DEPTH-1])
            begin
                for (int j = 1; j < DEPTH; j++)
                begin
                    notes_next[j] = notes_reg[j-1];
                    held_next[j]  = held_reg[j-1];
                end
            end
            notes_next[0] = cmd.note;
            held_next[0]  = 1'b1;
        end
        else if (cmd.remove)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
            begin
                if (IDX_W'(j) >= rm_idx)
                begin
                    notes_next[j] = notes_reg[j+1];
                    held_next[j]  = held_reg[j+1];
                end
            end
            notes_next[DEPTH-1] = '0;
            held_next[DEPTH-1]  = 1'b0;
        end
    end

    always_comb
    begin
        scan_note_next = scan_note_reg;
        scan_held_next = scan_held_reg;
        if (cmd.load_scan)
        begin
            scan_note_next = notes_reg;
            scan_held_next = held_reg;
        end
        else if (cmd.shift_scan)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
            begin
                scan_note_next[j] = scan_note_reg[j+1];
                scan_held_next[j] = scan_held_reg[j+1];
            end
            scan_note_next[DEPTH-1] = '0;
            scan_held_next[DEPTH-1] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                held_reg[j] <= 1'b0;
            end
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        notes_reg     <= notes_next;
        scan_note_reg <= scan_note_next;
        scan_held_reg <= scan_held_next;
    end

    always_comb
    begin
        stat.top_note    = notes_reg[0];
        stat.top_held    = held_reg[0];
        stat.second_held = held_reg[1];
        stat.scan_note   = scan_note_reg[0];
        stat.scan_held   = scan_held_reg[0];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/last_note_priority_voice.sv =====
// Top level: last-note-priority monophonic voice allocator
//
//  group   dir  signals                          content
//  s_axis  in   tvalid tready tdata[15:0] tuser  note event
//  m_axis  out  tvalid tready tdata[15:0]        voice state after the event
//  apb     in   psel penable pwrite paddr pwdata note range registers
//
// Note-on steps: accept, two range compares, result; the second compare is
// skipped when the note falls below the low bound.
// Note-off: the search walks one slot per cycle through
// the shared comparator.
// s_axis_tready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next result stalls until it is taken.
// Reset empties the stack and clears gate, legato and current note.
`default_nettype none
`include "last_note_priority_voice_defines.svh"

module last_note_priority_voice #(
    parameter int STACK_DEPTH = lnpv_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [6:0] note_number, [13:7] velocity, [15:14] zero
    input  wire logic [lnpv_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] func
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [6:0] active_note, [7] gate_on, [8] legato_on, [9] gate_started,
    // [10] gate_ended, [11] note_changed, [15:12] zero
    output logic [lnpv_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lnpv_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lnpv_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lnpv_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int NW    = lnpv_pkg::NOTE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE_LO,
        ST_RANGE_HI,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [NW-1:0]                   note_reg, note_next;
    logic                            apply_reg, apply_next;
    logic                            gate_reg, gate_next;
    logic                            legato_reg, legato_next;
    logic [NW-1:0]                   cur_note_reg, cur_note_next;
    logic                            out_valid_reg, out_valid_next;
    logic [lnpv_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [NW-1:0]                   lowest_reg, highest_reg;

    lnpv_pkg::stack_cmd_t  stk_cmd;
    lnpv_pkg::stack_stat_t stk_stat;
    lnpv_pkg::cmp_res_t    cmp_res;
    logic [NW-1:0]         cmp_a, cmp_b;
    logic                  cfg_wr;
    logic                  in_xfer;
    logic                  in_off;
    logic                  fin_load;
    logic                  now_gate;
    logic [NW-1:0]         new_note;
    logic                  started, ended, changed;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= lnpv_pkg::LOWEST_RST;
            highest_reg <= lnpv_pkg::HIGHEST_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                lnpv_pkg::REG_LOWEST:  lowest_reg  <= pwdata[NW-1:0];
                lnpv_pkg::REG_HIGHEST: highest_reg <= pwdata[NW-1:0];
                default:               lowest_reg  <= lowest_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lnpv_pkg::REG_LOWEST:  prdata = lnpv_pkg::APB_DATA_W'(lowest_reg);
            lnpv_pkg::REG_HIGHEST: prdata = lnpv_pkg::APB_DATA_W'(highest_reg);
            default:               prdata = '0;
        endcase
    end

    // datapath parts
    lnpv_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (stk_cmd),
        .rm_idx (idx_reg),
        .stat   (stk_stat)
    );

    lnpv_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_RANGE_LO:
            begin
                cmp_a = lowest_reg;
                cmp_b = note_reg;
            end
            ST_RANGE_HI:
            begin
                cmp_a = note_reg;
                cmp_b = highest_reg;
            end
            ST_FINISH:
            begin
                cmp_a = stk_stat.top_note;
                cmp_b = cur_note_reg;
            end
            default:
            begin
                cmp_a = stk_stat.scan_note;
                cmp_b = note_reg;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign in_off        = (s_axis_tuser == lnpv_pkg::FUNC_NOTE_OFF) ||
                           (s_axis_tdata[NW+lnpv_pkg::VEL_W-1:NW] == '0);

    // result of the event
    always_comb
    begin
        now_gate = stk_stat.top_held;
        new_note = now_gate ? stk_stat.top_note : '0;
        started  = apply_reg & now_gate & ~gate_reg;
        ended    = apply_reg & gate_reg & ~now_gate;
        changed  = apply_reg & ((now_gate != gate_reg) || (now_gate && !cmp_res.eq));
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        note_next      = note_reg;
        apply_next     = apply_reg;
        gate_next      = gate_reg;
        legato_next    = legato_reg;
        cur_note_next  = cur_note_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        fin_load       = 1'b0;
        stk_cmd        = '0;
        stk_cmd.note   = note_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    note_next         = s_axis_tdata[NW-1:0];
                    idx_next          = '0;
                    stk_cmd.load_scan = 1'b1;
                    state_next        = in_off ? ST_SEARCH : ST_RANGE_LO;
                end
            end
            ST_RANGE_LO:
            begin
                if (cmp_res.le)
                begin
                    state_next = ST_RANGE_HI;
                end
                else
                begin
                    apply_next = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_RANGE_HI:
            begin
                stk_cmd.push = cmp_res.le;
                apply_next   = cmp_res.le;
                state_next   = ST_FINISH;
            end
            ST_SEARCH:
            begin
                apply_next = 1'b1;
                if (!stk_stat.scan_held)
                begin
                    state_next = ST_FINISH;
                end
                else if (cmp_res.eq)
                begin
                    stk_cmd.remove = 1'b1;
                    state_next     = ST_FINISH;
                end
                else if (idx_reg == IDX_W'(STACK_DEPTH - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    stk_cmd.shift_scan = 1'b1;
                    idx_next           = idx_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    fin_load = 1'b1;
                    if (apply_reg)
                    begin
                        gate_next     = now_gate;
                        cur_note_next = new_note;
                        if (!now_gate || !gate_reg)
                        begin
                            legato_next = 1'b0;
                        end
                        else if (stk_stat.second_held)
                        begin
                            legato_next = 1'b1;
                        end
                    end
                    out_data_next  = {4'b0000, changed, ended, started,
                                      legato_next, gate_next, cur_note_next};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            apply_reg     <= 1'b0;
            gate_reg      <= 1'b0;
            legato_reg    <= 1'b0;
            cur_note_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            apply_reg     <= apply_next;
            gate_reg      <= gate_next;
            legato_reg    <= legato_next;
            cur_note_reg  <= cur_note_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg     <= note_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `LNPV_ASSERT(a_note_zero_when_off, !gate_reg |-> (cur_note_reg == '0), "note set while gate off")
    `LNPV_ASSERT(a_legato_needs_gate, legato_reg |-> gate_reg, "legato without gate")
    `LNPV_ASSERT(a_idle_gate_tracks_top, (state_reg == ST_IDLE) |-> (gate_reg == stk_stat.top_held), "gate differs from top slot")
    `LNPV_ASSERT_NEXT(a_finish_shows_result, fin_load, m_axis_tvalid && (state_reg == ST_IDLE), "result not presented")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the last-note-priority voice allocator: note events against a predicted voice state
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH         = lnpv_pkg::STACK_DEPTH_DEF;
    localparam int NOTE_W        = lnpv_pkg::NOTE_W;
    localparam int VEL_W         = lnpv_pkg::VEL_W;
    localparam int IN_DATA_W     = lnpv_pkg::IN_DATA_W;
    localparam int OUT_DATA_W    = lnpv_pkg::OUT_DATA_W;
    localparam int APB_ADDR_W    = lnpv_pkg::APB_ADDR_W;
    localparam int APB_DATA_W    = lnpv_pkg::APB_DATA_W;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_IDLE      = 11;
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 150;
    localparam int PRINT_CAP     = 50;

    typedef struct packed {
        logic [NOTE_W-1:0] active_note;
        logic              gate_on;
        logic              legato_on;
        logic              gate_started;
        logic              gate_ended;
        logic              note_changed;
    } voice_state_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [6:0] note_number, [13:7] velocity, [15:14] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [0] func
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [6:0] active_note, [7] gate_on, [8] legato_on, [9] gate_started,
    // [10] gate_ended, [11] note_changed, [15:12] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predicted block state
    logic [NOTE_W-1:0] stk_note [DEPTH];
    logic              stk_held [DEPTH];
    logic [NOTE_W-1:0] cur_note;
    logic              gate_q;
    logic              legato_q;
    logic [NOTE_W-1:0] range_lo;
    logic [NOTE_W-1:0] range_hi;

    voice_state_t pending_voice_q [$];
    int           err_count   = 0;
    int           idle_cycles = 0;
    int           rx_hold     = 0;
    logic         no_idle     = 1'b0;

    last_note_priority_voice #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int draw_idle();
        if (no_idle)
        begin
            return 0;
        end
        return int'($urandom_range(0, MAX_IDLE));
    endfunction

    task automatic reset_voice_model();
        for (int i = 0; i < DEPTH; i++)
        begin
            stk_note[i] = '0;
            stk_held[i] = 1'b0;
        end
        cur_note = '0;
        gate_q   = 1'b0;
        legato_q = 1'b0;
        range_lo = lnpv_pkg::LOWEST_RST;
        range_hi = lnpv_pkg::HIGHEST_RST;
    endtask

    function automatic voice_state_t predict_voice(logic func, logic [NOTE_W-1:0] note,
                                                   logic [VEL_W-1:0] vel);
        voice_state_t      res;
        logic              off;
        logic              was;
        logic              now;
        logic              found;
        logic              started;
        logic              ended;
        logic              changed;
        logic [NOTE_W-1:0] old_note;
        logic [NOTE_W-1:0] new_note;
        int                j;
        off     = (func == lnpv_pkg::FUNC_NOTE_OFF) || (vel == '0);
        started = 1'b0;
        ended   = 1'b0;
        changed = 1'b0;
        if (off || (note >= range_lo && note <= range_hi))
        begin
            was      = gate_q;
            old_note = cur_note;
            if (off)
            begin
                found = 1'b0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!found && stk_held[i] && stk_note[i] == note)
                    begin
                        found = 1'b1;
                        j     = i;
                        while (j + 1 < DEPTH && stk_held[j + 1])
                        begin
                            stk_note[j] = stk_note[j + 1];
                            j++;
                        end
                        stk_note[j] = '0;
                        stk_held[j] = 1'b0;
                    end
                end
            end
            else
            begin
                // full stack: top slot is overwritten, nothing shifts
                if (!stk_held[DEPTH - 1])
                begin
                    for (int i = DEPTH - 1; i > 0; i--)
                    begin
                        if (stk_held[i - 1])
                        begin
                            stk_note[i] = stk_note[i - 1];
                            stk_held[i] = 1'b1;
                        end
                    end
                end
                stk_note[0] = note;
                stk_held[0] = 1'b1;
            end
            now      = stk_held[0];
            new_note = now ? stk_note[0] : '0;
            changed  = (now != was) || (now && new_note != old_note);
            started  = now && !was;
            ended    = was && !now;
            if (!now || !was)
            begin
                legato_q = 1'b0;
            end
            else if (stk_held[1])
            begin
                legato_q = 1'b1;
            end
            cur_note = new_note;
            gate_q   = now;
        end
        res.active_note  = gate_q ? cur_note : '0;
        res.gate_on      = gate_q;
        res.legato_on    = legato_q;
        res.gate_started = started;
        res.gate_ended   = ended;
        res.note_changed = changed;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (err_count < PRINT_CAP)
        begin
            $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        err_count++;
    endtask

    task automatic check_voice(logic [OUT_DATA_W-1:0] data);
        voice_state_t want;
        if (pending_voice_q.size() == 0)
        begin
            report_mismatch("result without pending event", int'(data), 0);
        end
        else
        begin
            want = pending_voice_q.pop_front();
            if (data[6:0] != want.active_note)
                report_mismatch("active_note", int'(data[6:0]), int'(want.active_note));
            if (data[7] != want.gate_on)
                report_mismatch("gate_on", int'(data[7]), int'(want.gate_on));
            if (data[8] != want.legato_on)
                report_mismatch("legato_on", int'(data[8]), int'(want.legato_on));
            if (data[9] != want.gate_started)
                report_mismatch("gate_started", int'(data[9]), int'(want.gate_started));
            if (data[10] != want.gate_ended)
                report_mismatch("gate_ended", int'(data[10]), int'(want.gate_ended));
            if (data[11] != want.note_changed)
                report_mismatch("note_changed", int'(data[11]), int'(want.note_changed));
        end
    endtask

    // result side: random stall after each transfer
    always @(negedge clk)
    begin
        m_axis_tready <= (rx_hold == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_voice(m_axis_tdata);
            rx_hold = draw_idle();
        end
        else if (rx_hold > 0)
        begin
            rx_hold--;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_event(logic func, logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
        int gap;
        gap = draw_idle();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, vel, note};
        s_axis_tuser  <= func;
        do @(posedge clk); while (!s_axis_tready);
        pending_voice_q.push_back(predict_voice(func, note, vel));
    endtask

    task automatic wait_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_voice_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(logic idx, logic [NOTE_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W - NOTE_W){1'b0}}, val};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == lnpv_pkg::REG_LOWEST)
            range_lo = val;
        else
            range_hi = val;
    endtask

    task automatic apb_read(logic idx, output logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_range(logic [NOTE_W-1:0] lo, logic [NOTE_W-1:0] hi);
        logic [APB_DATA_W-1:0] rd;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(lnpv_pkg::REG_LOWEST, lo);
        apb_write(lnpv_pkg::REG_HIGHEST, hi);
        apb_read(lnpv_pkg::REG_LOWEST, rd);
        if (rd != {{(APB_DATA_W - NOTE_W){1'b0}}, lo})
            report_mismatch("lowest_note readback", int'(rd), int'(lo));
        apb_read(lnpv_pkg::REG_HIGHEST, rd);
        if (rd != {{(APB_DATA_W - NOTE_W){1'b0}}, hi})
            report_mismatch("highest_note readback", int'(rd), int'(hi));
    endtask

    task automatic test_directed();
        send_event(lnpv_pkg::FUNC_NOTE_OFF, 7'd0, 7'd0);      // note-off on empty stack
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd0, 7'd127);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd127, 7'd1);     // legato
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd127, 7'd64);    // same note twice
        send_event(lnpv_pkg::FUNC_NOTE_OFF, 7'd127, 7'd127);  // topmost copy only
        send_event(lnpv_pkg::FUNC_NOTE_OFF, 7'd127, 7'd0);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd0, 7'd0);       // zero velocity releases
        for (int k = 0; k <= DEPTH; k++)
            send_event(lnpv_pkg::FUNC_NOTE_ON, 7'(60 + k), 7'(1 << (k % VEL_W)));
        send_event(lnpv_pkg::FUNC_NOTE_OFF, 7'd63, 7'd42);    // middle entry
        // overwritten, no match
        send_event(lnpv_pkg::FUNC_NOTE_OFF, 7'(60 + DEPTH - 1), 7'd9);
        send_event(lnpv_pkg::FUNC_NOTE_OFF, 7'(60 + DEPTH), 7'd9);
    endtask

    task automatic test_note_range();
        set_range(7'd60, 7'd60);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd59, 7'd100);    // below range
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd61, 7'd100);    // above range
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd60, 7'd100);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd59, 7'd0);      // release outside range
        send_event(lnpv_pkg::FUNC_NOTE_OFF, 7'd60, 7'd5);
        set_range(7'd127, 7'd0);                              // inverted
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd127, 7'd10);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd0, 7'd10);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd64, 7'd10);
        send_event(lnpv_pkg::FUNC_NOTE_OFF, 7'd62, 7'd0);
        set_range(7'd0, 7'd0);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd0, 7'd127);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd1, 7'd127);
        set_range(7'd127, 7'd127);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd127, 7'd85);
        send_event(lnpv_pkg::FUNC_NOTE_ON, 7'd126, 7'd85);
        set_range(lnpv_pkg::LOWEST_RST, lnpv_pkg::HIGHEST_RST);
    endtask

    task automatic random_event();
        int                r;
        int                held_cnt;
        int                span;
        logic              func;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        held_cnt = 0;
        for (int i = 0; i < DEPTH; i++)
            if (stk_held[i])
                held_cnt++;
        r = int'($urandom_range(0, 99));
        if (r < 45)
        begin
            func = lnpv_pkg::FUNC_NOTE_ON;
            vel  = VEL_W'($urandom_range(1, 127));
            if (range_lo <= range_hi)
            begin
                span = int'(range_hi) - int'(range_lo);
                if (span > 5 && $urandom_range(0, 1))
                    span = 5;   // small pool to get repeats
                note = NOTE_W'(int'(range_lo) + int'($urandom_range(0, span)));
            end
            else
            begin
                note = NOTE_W'($urandom);
            end
        end
        else if (r < 85 && held_cnt > 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                func = lnpv_pkg::FUNC_NOTE_ON;
                vel  = '0;
            end
            else
            begin
                func = lnpv_pkg::FUNC_NOTE_OFF;
                vel  = VEL_W'($urandom);
            end
            note = stk_note[$urandom_range(0, held_cnt - 1)];
        end
        else
        begin
            func = 1'($urandom);
            note = NOTE_W'($urandom);
            vel  = ($urandom_range(0, 3) == 0) ? '0 : VEL_W'($urandom);
        end
        send_event(func, note, vel);
    endtask

    task automatic test_random();
        logic [NOTE_W-1:0] lo;
        logic [NOTE_W-1:0] hi;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase) inside
                2:
                begin
                    lo = 7'd0;
                    hi = 7'd0;
                end
                3:
                begin
                    lo = 7'd127;
                    hi = 7'd127;
                end
                4:
                begin
                    hi = NOTE_W'($urandom_range(0, 126));
                    lo = NOTE_W'($urandom_range(int'(hi) + 1, 127));
                end
                1, 5, 7:
                begin
                    lo = NOTE_W'($urandom_range(0, 127));
                    hi = NOTE_W'($urandom_range(int'(lo), 127));
                end
                default:
                begin
                    lo = lnpv_pkg::LOWEST_RST;
                    hi = lnpv_pkg::HIGHEST_RST;
                end
            endcase
            set_range(lo, hi);
            no_idle = (phase == 2 || phase == 6);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_results();
                random_event();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = lnpv_pkg::FUNC_NOTE_ON;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        reset_voice_model();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_note_range();
        test_random();

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_voice_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
